/* rtl/core/arvs_pkg.sv */
// Shared types, constants and the bytewise CRC-32 for the A/B record validator.
`default_nettype none

package arvs_pkg;

  localparam logic [31:0] REC_MAGIC   = 32'h3153_564B;
  localparam logic [31:0] REC_VERSION = 32'h0000_0001;
  localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;

  localparam int unsigned HDR_BYTES = 16;
  localparam int unsigned CRC_BYTES = 4;

  // last byte offset of each header word
  localparam int unsigned OFF_MAGIC_END   = 3;
  localparam int unsigned OFF_VERSION_END = 7;
  localparam int unsigned OFF_SEQ_END     = 11;
  localparam int unsigned OFF_LEN_END     = 15;

  localparam int unsigned LEN_OUT_W = 11;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // verdict of one finished record, front to back
  typedef struct packed {
    logic                 ok;
    logic                 slot;
    logic [31:0]          sequence_nr;
    logic [LEN_OUT_W-1:0] length;
  } rec_result_t;

  // reflected CRC-32, one byte
  function automatic logic [31:0] crc32_byte(input logic [31:0] acc_in,
                                             input logic [7:0]  data);
    logic [31:0] acc;
    acc = acc_in ^ {24'd0, data};
    for (int i = 0; i < 8; i++) begin
      acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/arvs_front.sv */
// Front end: per-byte header capture, CRC and record verdict.
`default_nettype none

module arvs_front #(
  parameter int unsigned STORE_BYTES = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 slot_id_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 end_of_record_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output arvs_pkg::rec_result_t push_data_o
);

  localparam int unsigned OffsetCap = arvs_pkg::HDR_BYTES + STORE_BYTES + arvs_pkg::CRC_BYTES;
  localparam int unsigned OffW      = $clog2(OffsetCap + 1);
  localparam int unsigned LenW      = $clog2(STORE_BYTES + 1);

  logic [OffW-1:0] off_q, off_d;
  logic [31:0]     shift_q, shift_d;
  logic            hdr_ok_q, hdr_ok_d;
  logic [31:0]     seq_q, seq_d;
  logic [LenW-1:0] plen_q, plen_d;
  logic [31:0]     crc_q, crc_d;
  logic            chk_q, chk_d;

  logic            take;
  logic            active;
  logic [OffW-1:0] plen_ext;
  logic            rec_ok;

  assign in_ready_o = ~q_full_i;
  assign take       = in_valid_i & in_ready_o;
  assign active     = off_q < OffW'(OffsetCap);
  assign plen_ext   = OffW'(plen_q);

  always_comb begin
    off_d    = off_q;
    shift_d  = shift_q;
    hdr_ok_d = hdr_ok_q;
    seq_d    = seq_q;
    plen_d   = plen_q;
    crc_d    = crc_q;
    chk_d    = chk_q;
    if (active) begin
      off_d   = off_q + OffW'(1);
      shift_d = {data_byte_i, shift_q[31:8]};
      if (off_q < plen_ext + OffW'(arvs_pkg::HDR_BYTES)) begin
        crc_d = arvs_pkg::crc32_byte(crc_q, data_byte_i);
      end
      if (off_q == OffW'(arvs_pkg::OFF_MAGIC_END) && shift_d != arvs_pkg::REC_MAGIC) begin
        hdr_ok_d = 1'b0;
      end
      if (off_q == OffW'(arvs_pkg::OFF_VERSION_END) && shift_d != arvs_pkg::REC_VERSION) begin
        hdr_ok_d = 1'b0;
      end
      if (off_q == OffW'(arvs_pkg::OFF_SEQ_END)) begin
        seq_d = shift_d;
      end
      if (off_q == OffW'(arvs_pkg::OFF_LEN_END)) begin
        if (shift_d > 32'(STORE_BYTES)) begin
          hdr_ok_d = 1'b0;
        end else begin
          plen_d = LenW'(shift_d);
        end
      end
      // last CRC byte; the running CRC has stopped by now
      if (off_q == plen_ext + OffW'(arvs_pkg::HDR_BYTES + arvs_pkg::CRC_BYTES - 1)) begin
        chk_d = (shift_d == ~crc_q);
      end
    end
  end

  assign rec_ok = hdr_ok_d & chk_d;

  assign push_o                  = take & end_of_record_i;
  assign push_data_o.ok          = rec_ok;
  assign push_data_o.slot        = slot_id_i;
  assign push_data_o.sequence_nr = rec_ok ? seq_d : 32'd0;
  assign push_data_o.length      = rec_ok ? arvs_pkg::LEN_OUT_W'(plen_d) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q    <= '0;
      shift_q  <= '0;
      hdr_ok_q <= 1'b1;
      seq_q    <= '0;
      plen_q   <= '0;
      crc_q    <= arvs_pkg::CRC_INIT;
      chk_q    <= 1'b0;
    end else if (take) begin
      if (end_of_record_i) begin
        off_q    <= '0;
        shift_q  <= '0;
        hdr_ok_q <= 1'b1;
        seq_q    <= '0;
        plen_q   <= '0;
        crc_q    <= arvs_pkg::CRC_INIT;
        chk_q    <= 1'b0;
      end else begin
        off_q    <= off_d;
        shift_q  <= shift_d;
        hdr_ok_q <= hdr_ok_d;
        seq_q    <= seq_d;
        plen_q   <= plen_d;
        crc_q    <= crc_d;
        chk_q    <= chk_d;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/arvs_queue.sv */
// Short queue of record verdicts between front and back.
`default_nettype none

module arvs_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  arvs_pkg::rec_result_t push_data_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  valid_o,
  output arvs_pkg::rec_result_t pop_data_o
);

  arvs_pkg::rec_result_t                mem_q [arvs_pkg::QUEUE_DEPTH];
  logic [arvs_pkg::QUEUE_PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [arvs_pkg::QUEUE_CNT_W-1:0]     cnt_q;
  logic                                 do_push, do_pop;

  assign full_o     = cnt_q == arvs_pkg::QUEUE_CNT_W'(arvs_pkg::QUEUE_DEPTH);
  assign valid_o    = cnt_q != '0;
  assign do_push    = push_i & ~full_o;
  assign do_pop     = pop_i & valid_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == arvs_pkg::QUEUE_PTR_W'(arvs_pkg::QUEUE_DEPTH - 1))
                    ? '0 : wr_ptr_q + arvs_pkg::QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == arvs_pkg::QUEUE_PTR_W'(arvs_pkg::QUEUE_DEPTH - 1))
                    ? '0 : rd_ptr_q + arvs_pkg::QUEUE_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + arvs_pkg::QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - arvs_pkg::QUEUE_CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/arvs_back.sv */
// Back end: running newest-valid choice and the output register.
`default_nettype none

module arvs_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  arvs_pkg::rec_result_t         q_data_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          record_ok_o,
  output logic [31:0]                   record_sequence_o,
  output logic [arvs_pkg::LEN_OUT_W-1:0] record_payload_length_o,
  output logic                          any_valid_o,
  output logic                          chosen_slot_o,
  output logic [31:0]                   chosen_sequence_o,
  output logic [arvs_pkg::LEN_OUT_W-1:0] chosen_length_o
);

  logic                          best_valid_q, best_valid_d;
  logic                          best_slot_q, best_slot_d;
  logic [31:0]                   best_seq_q, best_seq_d;
  logic [arvs_pkg::LEN_OUT_W-1:0] best_len_q, best_len_d;

  logic                          out_valid_q;
  arvs_pkg::rec_result_t         out_rec_q;
  logic                          wins;

  assign pop_o = q_valid_i & (~out_valid_q | out_ready_i);
  assign wins  = q_data_i.ok & (~best_valid_q | (q_data_i.sequence_nr > best_seq_q));

  always_comb begin
    best_valid_d = best_valid_q;
    best_slot_d  = best_slot_q;
    best_seq_d   = best_seq_q;
    best_len_d   = best_len_q;
    if (wins) begin
      best_valid_d = 1'b1;
      best_slot_d  = q_data_i.slot;
      best_seq_d   = q_data_i.sequence_nr;
      best_len_d   = q_data_i.length;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_valid_q <= 1'b0;
      best_slot_q  <= 1'b1;
      best_seq_q   <= '0;
      best_len_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (pop_o) begin
        best_valid_q <= best_valid_d;
        best_slot_q  <= best_slot_d;
        best_seq_q   <= best_seq_d;
        best_len_q   <= best_len_d;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_rec_q <= q_data_i;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign record_ok_o             = out_rec_q.ok;
  assign record_sequence_o       = out_rec_q.sequence_nr;
  assign record_payload_length_o = out_rec_q.length;
  // choice registers update together with the output register
  assign any_valid_o             = best_valid_q;
  assign chosen_slot_o           = best_slot_q;
  assign chosen_sequence_o       = best_seq_q;
  assign chosen_length_o         = best_len_q;

endmodule

`default_nettype wire

/* rtl/core/ab_record_validate_select_unit.sv */
// Top level of the A/B record validator and selector.
//
//   channel  dir  handshake               payload
//   in       in   in_valid_i/in_ready_o   slot_id_i, data_byte_i, end_of_record_i
//   out      out  out_valid_o/out_ready_i record_*_o, any_valid_o, chosen_*_o
//
// One byte item per cycle while in_ready_o is high; the CRC byte update and header
// capture are registered as the byte is accepted. An item marked end_of_record enters
// the queue at its accepting edge and the output register when the back end pops it.
// Reset clears the record state and the choice (slot B, sequence 0, length 0).
// The two-entry queue absorbs output stalls; in_ready_o drops only when it is full.
`default_nettype none

module ab_record_validate_select_unit #(
  parameter int unsigned STORE_BYTES = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          slot_id_i,
  input  logic [7:0]                    data_byte_i,
  input  logic                          end_of_record_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          record_ok_o,
  output logic [31:0]                   record_sequence_o,
  output logic [arvs_pkg::LEN_OUT_W-1:0] record_payload_length_o,
  output logic                          any_valid_o,
  output logic                          chosen_slot_o,
  output logic [31:0]                   chosen_sequence_o,
  output logic [arvs_pkg::LEN_OUT_W-1:0] chosen_length_o
);

  logic                  q_push, q_full, q_pop, q_valid;
  arvs_pkg::rec_result_t q_push_data, q_pop_data;

  arvs_front #(
    .STORE_BYTES(STORE_BYTES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .slot_id_i      (slot_id_i),
    .data_byte_i    (data_byte_i),
    .end_of_record_i(end_of_record_i),
    .q_full_i       (q_full),
    .push_o         (q_push),
    .push_data_o    (q_push_data)
  );

  arvs_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(q_push_data),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_data_o (q_pop_data)
  );

  arvs_back u_back (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .q_valid_i              (q_valid),
    .q_data_i               (q_pop_data),
    .pop_o                  (q_pop),
    .out_valid_o            (out_valid_o),
    .out_ready_i            (out_ready_i),
    .record_ok_o            (record_ok_o),
    .record_sequence_o      (record_sequence_o),
    .record_payload_length_o(record_payload_length_o),
    .any_valid_o            (any_valid_o),
    .chosen_slot_o          (chosen_slot_o),
    .chosen_sequence_o      (chosen_sequence_o),
    .chosen_length_o        (chosen_length_o)
  );

`ifndef ASSERT_OFF
  a_no_queue_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full))
    else $error("verdict pushed into full queue");

  a_invalid_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !record_ok_o) |->
      (record_sequence_o == 32'd0 && record_payload_length_o == '0))
    else $error("invalid record carries nonzero fields");

  a_ok_implies_any: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && record_ok_o) |-> any_valid_o)
    else $error("valid record but no choice held");

  a_none_default: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !any_valid_o) |->
      (chosen_slot_o && chosen_sequence_o == 32'd0 && chosen_length_o == '0))
    else $error("default choice wrong when nothing valid");
`endif

endmodule

`default_nettype wire
